// ===== rtl/sha256_byte_stream_hasher_macros.svh =====
// Assertion macros for the SHA-256 hasher
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SHA_ASSERT(label, clk, rst_n, prop, msg)
`define SHA_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/sha_pkg.sv =====
package sha_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef logic [31:0] word_t;

	// Command from the front end to the compression engine
	typedef struct packed {
		logic [511:0] block;
		logic         finish;
	} blk_cmd_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_ROUND,
		ENG_ADD,
		ENG_EMIT
	} eng_state_t;

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		unique case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_h(input logic [2:0] idx);
		word_t h;
		unique case (idx)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher.sv =====
// Compression: a block passes through load, 64 rounds and add in the compression engine.
// Input: one byte per cycle, but push is held off while a full block waits to be handed
// to the block queue and while padding runs; the engine takes one block at a time.
// Message end: padding bytes are shifted in one per cycle while no block waits for the queue,
// filling one or two blocks; eight digest words are offered once the last block is compressed.
// arst_n low clears fill, length, queue and engine and loads the initial hash values.
`include "sha256_byte_stream_hasher_macros.svh"
module sha256_byte_stream_hasher import sha_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        msg_end,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	logic     cmd_push, cmd_full, qpop, qempty;
	blk_cmd_t cmd, qdata;

	sha_front u_front (
		.clk, .arst_n, .push, .full, .msg_byte, .byte_valid, .msg_end,
		.cmd_push, .cmd, .cmd_full
	);

	sha_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .wr(cmd_push), .wdata(cmd), .qfull(cmd_full),
		.rd(qpop), .rdata(qdata), .qempty
	);

	sha_engine u_engine (
		.clk, .arst_n, .qempty, .qdata, .qpop, .empty, .pop,
		.digest_word, .word_index, .last_word
	);

	`SHA_ASSERT_NEVER(a_no_overflow, clk, arst_n, cmd_push && cmd_full, "queue overflow")
	`SHA_ASSERT_NEVER(a_no_underflow, clk, arst_n, qpop && qempty, "queue underflow")
	`SHA_ASSERT(a_last_idx, clk, arst_n, (!empty && last_word) |-> (word_index == 3'd7), "bad last")
endmodule

// ===== rtl/sha_front.sv =====
// Gathers bytes into blocks, pads at message end, pushes blocks to the queue
module sha_front import sha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [7:0]   msg_byte,
	input  logic         byte_valid,
	input  logic         msg_end,
	output logic         cmd_push,
	output blk_cmd_t     cmd,
	input  logic         cmd_full
);
	// block shift register: the oldest byte ends up in the top bits
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [63:0]  total_q;
	// padding sequence: pad_q = padding under way, first_q = 0x80 still to go,
	// len_blk_q = the current block carries the bit length
	logic         pad_q;
	logic         first_q;
	logic         len_blk_q;
	// completed block waiting for the queue; fin_blk_q = it closes the message
	logic         blk_rdy_q;
	logic         fin_blk_q;

	logic       accept;
	logic       pad_step;
	logic       shift_en;
	logic [7:0] pad_byte;
	logic [7:0] shift_byte;
	logic [6:0] nf;

	assign full     = pad_q | blk_rdy_q;
	assign accept   = push & ~full;
	assign pad_step = pad_q & ~blk_rdy_q;
	assign nf       = {1'b0, fill_q} + 7'(byte_valid);
	assign cmd_push = blk_rdy_q & ~cmd_full;
	assign cmd      = {blk_q, fin_blk_q};

	// Pick the next padding byte: marker, zeros, then the length big-endian
	always_comb begin
		if (first_q)
			pad_byte = 8'h80;
		else if (len_blk_q && fill_q >= 6'd56)
			pad_byte = total_q[{~fill_q[2:0], 3'b000} +: 8];
		else
			pad_byte = 8'h00;
		shift_en   = pad_step | (accept & byte_valid);
		shift_byte = pad_step ? pad_byte : msg_byte;
	end

	// Shift in a message or padding byte
	always_ff @(posedge clk) begin
		if (shift_en) blk_q <= {blk_q[503:0], shift_byte};
	end

	// Advance fill, length and padding sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; len_q <= '0; total_q <= '0; pad_q <= 1'b0; first_q <= 1'b0;
			len_blk_q <= 1'b0; blk_rdy_q <= 1'b0; fin_blk_q <= 1'b0;
		end else if (cmd_push) begin
			blk_rdy_q <= 1'b0;
		end else if (pad_step) begin
			first_q <= 1'b0;
			if (fill_q == 6'd63) begin
				blk_rdy_q <= 1'b1;
				fin_blk_q <= len_blk_q;
				fill_q    <= '0;
				if (len_blk_q) pad_q <= 1'b0;
				else len_blk_q <= 1'b1;
			end else begin
				fill_q <= fill_q + 6'd1;
			end
		end else if (accept) begin
			if (nf == 7'd64) begin
				blk_rdy_q <= 1'b1;
				fin_blk_q <= 1'b0;
				fill_q    <= '0;
			end else begin
				fill_q <= nf[5:0];
			end
			if (msg_end) begin
				pad_q     <= 1'b1;
				first_q   <= 1'b1;
				len_blk_q <= (nf < 7'd56) | nf[6];
				total_q   <= len_q + {54'd0, nf, 3'd0};
				len_q     <= '0;
			end else if (nf == 7'd64) begin
				len_q <= len_q + 64'd512;
			end
		end
	end
endmodule

// ===== rtl/sha_queue.sv =====
// Short block queue between front end and engine
module sha_queue import sha_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  blk_cmd_t wdata,
	output logic     qfull,
	input  logic     rd,
	output blk_cmd_t rdata,
	output logic     qempty
);
	localparam int AW = $clog2(DEPTH);
	blk_cmd_t    mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign qempty = wp_q == rp_q;
	assign qfull  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign rdata  = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q[AW-1:0]] <= wdata;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

// ===== rtl/sha_engine.sv =====
// Runs 64 compression rounds per block, one per cycle, and emits the digest
module sha_engine import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        qempty,
	input  blk_cmd_t    qdata,
	output logic        qpop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	eng_state_t st_q, st_d;
	word_t      h_q [8];
	word_t      v_q [8];
	word_t      w_q [16];
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;

	word_t s0, s1, wn, t1, t2, ch, mj, wt;

	// Message schedule and round function
	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		wn = s1 + w_q[9] + s0 + w_q[0];
		wt = w_q[0];
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + ({v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]}) + ch + round_k(rnd_q) + wt;
		t2 = ({v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]}) + mj;
	end

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ENG_IDLE:  if (!qempty) st_d = ENG_ROUND;
			ENG_ROUND: if (rnd_q == 6'd63) st_d = ENG_ADD;
			ENG_ADD:   st_d = fin_q ? ENG_EMIT : ENG_IDLE;
			ENG_EMIT:  if (pop && idx_q == 3'd7) st_d = ENG_IDLE;
			default:   st_d = ENG_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		qpop        = st_q == ENG_IDLE && !qempty;
		empty       = st_q != ENG_EMIT;
		digest_word = h_q[idx_q];
		word_index  = idx_q;
		last_word   = idx_q == 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ENG_IDLE; rnd_q <= '0; idx_q <= '0; fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ENG_IDLE: begin
					rnd_q <= '0; idx_q <= '0;
					if (!qempty) fin_q <= qdata.finish;
				end
				ENG_ROUND: rnd_q <= rnd_q + 6'd1;
				ENG_ADD: for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				ENG_EMIT: if (pop) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7)
						for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
				end
				default: ;
			endcase
		end
	end

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (st_q == ENG_IDLE && !qempty) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= qdata.block[32 * (15 - i) +: 32];
		end else if (st_q == ENG_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
		end
	end
endmodule

// ===== dv/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// Expected digest words, with a private SHA-256 predictor
class sha256_digest_board;
	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	digest_entry_t expected_words[$];
	logic [31:0]   hash_state[8];
	logic [7:0]    block_bytes[64];
	int unsigned   fill;
	logic [63:0]   completed_bits;
	int unsigned   mismatches;

	function new();
		mismatches = 0;
		restart();
	endfunction

	function void restart();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill = 0;
		completed_bits = '0;
	endfunction

	function logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function logic [31:0] round_const(int t);
		logic [31:0] k[64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[t];
	endfunction

	function void compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++)
			hash_state[t] += v[t];
	endfunction

	// Absorb one transaction; on message end pad, finish and queue eight words
	function void note_input(logic [7:0] data, logic has_byte, logic is_end);
		logic [63:0] total;
		int unsigned i;
		digest_entry_t e;
		if (has_byte) begin
			block_bytes[fill] = data;
			fill++;
			if (fill == 64) begin
				compress();
				completed_bits += 64'd512;
				fill = 0;
			end
		end
		if (!is_end)
			return;
		total = completed_bits + 64'(fill * 8);
		i = fill;
		block_bytes[i++] = 8'h80;
		if (i > 56) begin
			while (i < 64) block_bytes[i++] = 8'h00;
			compress();
			i = 0;
		end
		while (i < 56) block_bytes[i++] = 8'h00;
		for (int b = 0; b < 8; b++)
			block_bytes[56+b] = total[63-8*b -: 8];
		compress();
		for (int j = 0; j < 8; j++) begin
			e.word = hash_state[j];
			e.index = 3'(j);
			e.last = (j == 7);
			expected_words.push_back(e);
		end
		restart();
	endfunction

	// Compare one popped word against the oldest expectation
	function void check_word(logic [31:0] word, logic [2:0] index, logic last);
		digest_entry_t e;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected digest word %h index %0d", word, index);
			return;
		end
		e = expected_words.pop_front();
		if (word !== e.word || index !== e.index || last !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("digest word: expected %h/%0d/%0b, got %h/%0d/%0b",
					e.word, e.index, e.last, word, index, last);
		end
	endfunction
endclass

module tb_sha256_byte_stream_hasher;
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  msg_byte;
	logic        byte_valid;
	logic        msg_end;
	logic        empty;
	logic        pop;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	localparam int STALL_LIMIT = 20000;

	sha256_digest_board board;
	int unsigned idle_cycles = 0;
	bit          pop_enable;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.msg_byte(msg_byte), .byte_valid(byte_valid), .msg_end(msg_end),
		.empty(empty), .pop(pop), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Present one transaction and hold it until accepted; push stays high for the next one
	task automatic send_item(logic [7:0] data, logic has_byte, logic is_end, bit gaps);
		int unsigned g;
		g = gaps ? gap_length() : 0;
		if (g != 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		msg_byte <= data;
		byte_valid <= has_byte;
		msg_end <= is_end;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_input(data, has_byte, is_end);
	endtask

	task automatic send_message(int unsigned len, bit end_with_byte, bit gaps);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1), gaps);
		if (!end_with_byte || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1, gaps);
	endtask

	// Drop push and hold off until every expected word has been popped
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (board.expected_words.size() != 0) @(posedge clk);
	endtask

	// Randomly stall the result side; some stretches run flat out
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= pop_enable ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	initial begin
		pop_enable = 1'b0;
		forever begin
			repeat ($urandom_range(50, 400)) @(posedge clk);
			pop_enable = ~pop_enable;
		end
	end

	// Check each accepted digest word and watch for lack of progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				board.check_word(digest_word, word_index, last_word);
			if ((pop && !empty) || (push && !full))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("sha256_byte_stream_hasher: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned len;
		board = new();
		arst_n = 1'b0;
		push = 1'b0;
		msg_byte = 8'h00;
		byte_valid = 1'b0;
		msg_end = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, neither-flag item, extreme bytes, short messages
		send_item(8'h00, 1'b0, 1'b1, 0);
		send_item(8'hff, 1'b0, 1'b0, 0);
		send_item(8'hff, 1'b1, 1'b1, 0);
		send_item(8'h00, 1'b1, 1'b0, 0);
		send_item(8'hff, 1'b1, 1'b0, 0);
		send_item(8'h55, 1'b0, 1'b1, 0);
		send_item(8'haa, 1'b1, 1'b1, 0);
		wait_drained();

		// Random messages; lengths around the padding and block boundaries
		sent = 0;
		while (sent < 230) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(54, 57);
				1: len = $urandom_range(62, 66);
				2: len = $urandom_range(118, 130);
				default: len = $urandom_range(0, 12);
			endcase
			send_message(len, $urandom_range(0, 1), 1);
			if ($urandom_range(0, 4) == 0)
				send_item(8'($urandom), 1'b0, 1'b0, 1);
			sent += len + 1;
			if (sent > 100 && sent < 140)
				wait_drained();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.expected_words.size() == 0)
			$display("sha256_byte_stream_hasher: match");
		else
			$display("sha256_byte_stream_hasher: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_queue.sv
rtl/sha_engine.sv
rtl/sha256_byte_stream_hasher.sv
dv/tb_sha256_byte_stream_hasher.sv
